// ===== rtl/paaf_pkg.sv =====
`default_nettype none

package paaf_pkg;

    localparam int MAX_SAMPLES_DEF = 64;

    localparam int SAMPLE_W   = 16;
    localparam int AVG_W      = 16;
    localparam int ANGLE_W    = 41;
    localparam int COUNT_W    = 7;
    localparam int SCALE_W    = 25;
    localparam int DIFF_W     = AVG_W + 1;
    localparam int PROD_W     = DIFF_W + SCALE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_COUNT = 3'd0,
        REG_POT_CENTER   = 3'd1,
        REG_SCALE_LEFT   = 3'd2,
        REG_SCALE_RIGHT  = 3'd3,
        REG_MIN_VALID    = 3'd4,
        REG_MAX_VALID    = 3'd5
    } cfg_reg_t;

    localparam logic [COUNT_W-1:0]  SAMPLE_COUNT_RST = 7'd4;
    localparam logic [AVG_W-1:0]    POT_CENTER_RST   = 16'd2048;
    localparam logic [SCALE_W-1:0]  SCALE_RST        = '0;
    localparam logic [AVG_W-1:0]    MIN_VALID_RST    = 16'd0;
    localparam logic [AVG_W-1:0]    MAX_VALID_RST    = 16'd4095;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic block_done;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/paaf_ctrl.sv =====
`default_nettype none

module paaf_ctrl
    import paaf_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    localparam int SUM_W  = SAMPLE_W + $clog2(MAX_SAMPLES);
    localparam int STEP_W = $clog2(SUM_W + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    if (status.block_done)
                    begin
                        state_next = ST_DIV;
                        step_next  = '0;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (!status.out_busy)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/paaf_dp.sv =====
`default_nettype none

module paaf_dp
    import paaf_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  m_tready,
    input  wire ctrl_cmd_t             cmd,
    output dp_status_t                 status,
    output logic                       m_tvalid,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tuser
);

    localparam int SUM_W = SAMPLE_W + $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    // configuration
    logic [COUNT_W-1:0]        sample_count_reg;
    logic [AVG_W-1:0]          pot_center_reg;
    logic signed [SCALE_W-1:0] scale_left_reg;
    logic signed [SCALE_W-1:0] scale_right_reg;
    logic [AVG_W-1:0]          min_valid_reg;
    logic [AVG_W-1:0]          max_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= SAMPLE_COUNT_RST;
            pot_center_reg   <= POT_CENTER_RST;
            scale_left_reg   <= SCALE_RST;
            scale_right_reg  <= SCALE_RST;
            min_valid_reg    <= MIN_VALID_RST;
            max_valid_reg    <= MAX_VALID_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_idx)
                REG_SAMPLE_COUNT: sample_count_reg <= cfg_data[COUNT_W-1:0];
                REG_POT_CENTER:   pot_center_reg   <= cfg_data[AVG_W-1:0];
                REG_SCALE_LEFT:   scale_left_reg   <= cfg_data[SCALE_W-1:0];
                REG_SCALE_RIGHT:  scale_right_reg  <= cfg_data[SCALE_W-1:0];
                REG_MIN_VALID:    min_valid_reg    <= cfg_data[AVG_W-1:0];
                REG_MAX_VALID:    max_valid_reg    <= cfg_data[AVG_W-1:0];
                default:          ;
            endcase
        end
    end

    // accumulator
    logic [SUM_W-1:0] sum_reg, sum_next, sum_inc;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_inc;
    logic [CMP_W-1:0] blk_size, cnt_ext;

    always_comb
    begin
        cnt_ext = CMP_W'(sample_count_reg);
        if (sample_count_reg == '0)
        begin
            blk_size = CMP_W'(1);
        end
        else if (cnt_ext > CMP_W'(MAX_SAMPLES))
        begin
            blk_size = CMP_W'(MAX_SAMPLES);
        end
        else
        begin
            blk_size = cnt_ext;
        end
    end

    assign sum_inc           = sum_reg + SUM_W'(s_tdata);
    assign cnt_inc           = cnt_reg + CNT_W'(1);
    assign status.block_done = CMP_W'(cnt_inc) >= blk_size;

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (cmd.accept)
        begin
            if (status.block_done)
            begin
                sum_next = '0;
                cnt_next = '0;
            end
            else
            begin
                sum_next = sum_inc;
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

    // restoring divider, one quotient bit per step
    logic [SUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] dvs_reg;
    logic [CNT_W:0]   trial, trial_sub;
    logic             trial_ge;

    assign trial     = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_ge  = trial >= {1'b0, dvs_reg};
    assign trial_sub = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.accept && status.block_done)
        begin
            quo_reg <= sum_inc;
            rem_reg <= '0;
            dvs_reg <= cnt_inc;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], trial_ge};
            rem_reg <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    // calibration and output register
    logic [AVG_W-1:0]          avg;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [SCALE_W-1:0] scale;
    logic signed [PROD_W-1:0]  prod;
    logic                      fault;
    logic                      out_valid_reg;
    logic [AVG_W-1:0]          avg_reg;
    logic [ANGLE_W-1:0]        angle_reg;
    logic                      fault_reg;

    assign avg   = quo_reg[AVG_W-1:0];
    assign diff  = $signed({1'b0, avg}) - $signed({1'b0, pot_center_reg});
    assign scale = (diff <= 0) ? scale_left_reg : scale_right_reg;
    assign prod  = diff * scale;
    assign fault = (avg < min_valid_reg) || (avg > max_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            avg_reg   <= avg;
            angle_reg <= prod[ANGLE_W-1:0];
            fault_reg <= fault;
        end
    end

    assign status.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {(M_TDATA_W - AVG_W - ANGLE_W)'(0), angle_reg, avg_reg};
    assign m_tuser         = fault_reg;

endmodule

`default_nettype wire

// ===== rtl/pot_average_angle_fault.sv =====
// Steering pot block averager with two-slope angle calibration.
//
// Input stream (s_*): one beat per raw ADC count in s_tdata[15:0].
// Output stream (m_*): one beat per completed block of sample_count samples (0 taken as 1, capped at MAX_SAMPLES):
//   m_tdata = {angle_q24[40:0], average[15:0]} (zero padded to 64 bits),
//   m_tuser = pot_fault.
// Config port: cfg_wen writes cfg_data into register cfg_idx at the clock
//   edge (0 sample_count, 1 pot_center, 2 scale_left, 3 scale_right,
//   4 min_valid, 5 max_valid); write only while the block is idle.
// Timing: s_tready stays high after a sample that does not close a block. The beat
//   that closes a block starts the restoring divider, one quotient bit per
//   cycle, and then a multiply/load step that waits while a stalled result
//   still holds the output register; s_tready is low from that beat until
//   the load.
// The output register holds one result; new samples are taken while it
//   waits. If the receiver stalls, the next block's result waits in the
//   divider until the register empties.
// Reset clears the running sum, sample count and output valid, and loads
//   the configuration registers with their defaults.
`default_nettype none

module pot_average_angle_fault
    import paaf_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // sample[15:0]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // average[15:0], angle_q24[56:16]
    output logic                       m_tuser    // pot_fault
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    paaf_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    paaf_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_load_outside_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result loaded while accepting samples");

    a_leave_idle_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("left idle without an accepted beat");

    a_load_not_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !(m_tvalid && !m_tready))
        else $error("result overwrites a pending beat");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none

module tb;
    import paaf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 40;
    localparam int RAND_ITEMS    = 1250;
    localparam int GAP_MAX       = 18;

    // indexes past the register map, written to check they are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [AVG_W-1:0]   avg;
        logic [ANGLE_W-1:0] angle;
        logic               fault;
    } pot_result_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_SAMPLE
    } row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   value;
        logic                    typed;
        pot_result_t             want;
    } dir_row_t;

    localparam pot_result_t NO_RES = '0;
    localparam int DIR_LEN = 41;

    localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
        // defaults after reset: 4 samples, both scales zero
        '{ROW_SAMPLE, '0, 25'd0,     1'b0, NO_RES},
        '{ROW_SAMPLE, '0, 25'd0,     1'b0, NO_RES},
        '{ROW_SAMPLE, '0, 25'd0,     1'b0, NO_RES},
        '{ROW_SAMPLE, '0, 25'd0,     1'b1, '{16'd0, 41'd0, 1'b0}},
        '{ROW_SAMPLE, '0, 25'd65535, 1'b0, NO_RES},
        '{ROW_SAMPLE, '0, 25'd65535, 1'b0, NO_RES},
        '{ROW_SAMPLE, '0, 25'd65535, 1'b0, NO_RES},
        '{ROW_SAMPLE, '0, 25'd65535, 1'b1, '{16'd65535, 41'd0, 1'b1}},
        // full-scale angles
        '{ROW_WRITE, REG_SAMPLE_COUNT, 25'd1,         1'b0, NO_RES},
        '{ROW_WRITE, REG_SCALE_LEFT,   25'h1000001,   1'b0, NO_RES},
        '{ROW_WRITE, REG_SCALE_RIGHT,  25'h0FFFFFF,   1'b0, NO_RES},
        '{ROW_WRITE, REG_POT_CENTER,   25'd0,         1'b0, NO_RES},
        '{ROW_SAMPLE, '0, 25'd65535, 1'b1, '{16'd65535, 41'sd1099494785025, 1'b1}},
        '{ROW_SAMPLE, '0, 25'd0,     1'b1, '{16'd0, 41'd0, 1'b0}},
        '{ROW_WRITE, REG_POT_CENTER,   25'd65535,     1'b0, NO_RES},
        '{ROW_SAMPLE, '0, 25'd0,     1'b1, '{16'd0, 41'sd1099494785025, 1'b0}},
        '{ROW_WRITE, REG_SCALE_LEFT,   25'h0FFFFFF,   1'b0, NO_RES},
        '{ROW_SAMPLE, '0, 25'd0,     1'b1, '{16'd0, -41'sd1099494785025, 1'b0}},
        '{ROW_WRITE, REG_SCALE_LEFT,   25'h1000000,   1'b0, NO_RES},
        '{ROW_SAMPLE, '0, 25'd0,     1'b0, NO_RES},
        // zero block size, inverted window
        '{ROW_WRITE, REG_SAMPLE_COUNT, 25'd0,         1'b0, NO_RES},
        '{ROW_WRITE, REG_POT_CENTER,   25'd2048,      1'b0, NO_RES},
        '{ROW_WRITE, REG_MIN_VALID,    25'd5000,      1'b0, NO_RES},
        '{ROW_WRITE, REG_MAX_VALID,    25'd100,       1'b0, NO_RES},
        '{ROW_SAMPLE, '0, 25'd3000,  1'b0, NO_RES},
        '{ROW_WRITE, REG_MIN_VALID,    25'd0,         1'b0, NO_RES},
        '{ROW_WRITE, REG_MAX_VALID,    25'd65535,     1'b0, NO_RES},
        // block size lowered while the block holds three samples
        '{ROW_WRITE, REG_SAMPLE_COUNT, 25'd8,         1'b0, NO_RES},
        '{ROW_SAMPLE, '0, 25'd100,   1'b0, NO_RES},
        '{ROW_SAMPLE, '0, 25'd200,   1'b0, NO_RES},
        '{ROW_SAMPLE, '0, 25'd300,   1'b0, NO_RES},
        '{ROW_WRITE, REG_SAMPLE_COUNT, 25'd2,         1'b0, NO_RES},
        '{ROW_SAMPLE, '0, 25'd400,   1'b0, NO_RES},
        // writes to unmapped indexes change nothing
        '{ROW_WRITE, REG_SPARE_A,      25'h1FFFFFF,   1'b0, NO_RES},
        '{ROW_WRITE, REG_SPARE_B,      25'h1FFFFFF,   1'b0, NO_RES},
        '{ROW_SAMPLE, '0, 25'd5,     1'b0, NO_RES},
        '{ROW_SAMPLE, '0, 25'd7,     1'b0, NO_RES},
        '{ROW_WRITE, REG_SAMPLE_COUNT, 25'd3,         1'b0, NO_RES},
        '{ROW_SAMPLE, '0, 25'd65535, 1'b0, NO_RES},
        '{ROW_SAMPLE, '0, 25'd65535, 1'b0, NO_RES},
        '{ROW_SAMPLE, '0, 25'd65534, 1'b0, NO_RES}
    };

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_wen;
    logic [CFG_IDX_W-1:0]    cfg_idx;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tuser;

    // mirror of the block's registers and accumulator
    logic [COUNT_W-1:0]      cur_count;
    logic [AVG_W-1:0]        cur_center;
    logic signed [SCALE_W-1:0] cur_left;
    logic signed [SCALE_W-1:0] cur_right;
    logic [AVG_W-1:0]        cur_min;
    logic [AVG_W-1:0]        cur_max;
    longint                  blk_sum;
    int                      blk_taken;

    pot_result_t             owed_readings [$];
    int                      bad_beats;
    bit                      tx_burst;
    bit                      rx_burst;

    pot_average_angle_fault u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void note_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SAMPLE_COUNT: cur_count  = data[COUNT_W-1:0];
            REG_POT_CENTER:   cur_center = data[AVG_W-1:0];
            REG_SCALE_LEFT:   cur_left   = data[SCALE_W-1:0];
            REG_SCALE_RIGHT:  cur_right  = data[SCALE_W-1:0];
            REG_MIN_VALID:    cur_min    = data[AVG_W-1:0];
            REG_MAX_VALID:    cur_max    = data[AVG_W-1:0];
            default: ;
        endcase
    endfunction

    // accumulate one sample; returns 1 with the reading when the block closes
    function automatic bit fold_sample(input logic [SAMPLE_W-1:0] s,
                                       output pot_result_t r);
        int     lim;
        longint avg;
        longint diff;
        longint scl;
        longint prod;
        lim = (cur_count == 0) ? 1
            : (int'(cur_count) > MAX_SAMPLES_DEF) ? MAX_SAMPLES_DEF : int'(cur_count);
        blk_sum   += longint'(s);
        blk_taken += 1;
        r = '0;
        if (blk_taken < lim)
            return 1'b0;
        avg = blk_sum / blk_taken;
        if (avg > 65535)
            avg = 65535;
        diff = avg - longint'(cur_center);
        scl  = (diff <= 0) ? longint'(cur_left) : longint'(cur_right);
        prod = diff * scl;
        r.avg   = avg[AVG_W-1:0];
        r.angle = prod[ANGLE_W-1:0];
        r.fault = (avg < longint'(cur_min)) || (avg > longint'(cur_max));
        blk_sum   = 0;
        blk_taken = 0;
        return 1'b1;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wen  <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        note_reg(idx, data);
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic put_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                              input pot_result_t want);
        int          gap;
        bit          had;
        pot_result_t got;
        gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        had = fold_sample(s, got);
        if (had)
            owed_readings.push_back(typed ? want : got);
    endtask

    // drain all readings, then cover a block still in the divider
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (owed_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // output side: random stalls, compare each beat with the oldest reading
    initial
    begin
        int          gap;
        pot_result_t w;
        m_tready = 1'b0;
        rx_burst = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
            @(negedge clk);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            if (owed_readings.size() == 0)
            begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display("tb: unexpected beat avg %0d angle %0d fault %0b",
                             m_tdata[15:0], $signed(m_tdata[56:16]), m_tuser);
            end
            else
            begin
                w = owed_readings.pop_front();
                if (m_tdata[15:0] !== w.avg || m_tdata[56:16] !== w.angle
                    || m_tuser !== w.fault)
                begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("tb: mismatch avg %0d/%0d angle %0d/%0d fault %0b/%0b (exp/got)",
                                 w.avg, m_tdata[15:0], $signed(w.angle),
                                 $signed(m_tdata[56:16]), w.fault, m_tuser);
                end
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        int                  sent;
        int                  n;
        bit                  dirty;
        logic [15:0]         smp;
        logic [CFG_DATA_W-1:0] v;
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        rst_n    = 1'b0;
        cfg_wen  = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        bad_beats = 0;
        tx_burst  = 1'b0;
        cur_count  = SAMPLE_COUNT_RST;
        cur_center = POT_CENTER_RST;
        cur_left   = SCALE_RST;
        cur_right  = SCALE_RST;
        cur_min    = MIN_VALID_RST;
        cur_max    = MAX_VALID_RST;
        blk_sum    = 0;
        blk_taken  = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        dirty = 1'b0;
        for (int i = 0; i < DIR_LEN; i++)
        begin
            if (DIR_ROWS[i].kind == ROW_WRITE)
            begin
                if (dirty)
                    settle();
                dirty = 1'b0;
                write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].value);
            end
            else
            begin
                put_sample(DIR_ROWS[i].value[15:0], DIR_ROWS[i].typed, DIR_ROWS[i].want);
                dirty = 1'b1;
            end
        end

        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            settle();
            case ($urandom_range(0, 9))
                0:       v = 25'd0;
                1:       v = 25'd64;
                2:       v = 25'($urandom_range(65, 127));
                3:       v = 25'($urandom_range(9, 63));
                default: v = 25'($urandom_range(1, 8));
            endcase
            write_reg(REG_SAMPLE_COUNT, {18'($urandom), v[6:0]});
            case ($urandom_range(0, 4))
                0:       v = 25'd0;
                1:       v = 25'd65535;
                2:       v = 25'($urandom);
                default: v = 25'($urandom_range(1500, 2600));
            endcase
            write_reg(REG_POT_CENTER, {9'($urandom), v[15:0]});
            for (int k = 0; k < 2; k++)
            begin
                case ($urandom_range(0, 5))
                    0:       v = 25'h0FFFFFF;
                    1:       v = 25'h1000001;
                    2:       v = 25'h1000000;
                    3:       v = 25'd0;
                    default: v = 25'($urandom);
                endcase
                write_reg(k == 0 ? REG_SCALE_LEFT : REG_SCALE_RIGHT, v);
            end
            case ($urandom_range(0, 4))
                0:
                begin
                    lo = 25'd0;
                    hi = 25'd65535;
                end
                1:
                begin
                    hi = 25'($urandom_range(0, 30000));
                    lo = 25'($urandom_range(30001, 65535));
                end
                2:
                begin
                    lo = 25'($urandom);
                    hi = 25'($urandom);
                end
                default:
                begin
                    lo = 25'($urandom_range(0, 1000));
                    hi = 25'($urandom_range(3000, 4095));
                end
            endcase
            write_reg(REG_MIN_VALID, {9'($urandom), lo[15:0]});
            write_reg(REG_MAX_VALID, {9'($urandom), hi[15:0]});
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 25'($urandom));

            tx_burst = ($urandom_range(0, 3) == 0);
            n = $urandom_range(10, 80);
            repeat (n)
            begin
                case ($urandom_range(0, 9))
                    0:       smp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    1, 2, 3: smp = 16'($urandom);
                    4, 5, 6: smp = 16'($urandom_range(cur_min, cur_max));
                    default: smp = cur_center + 16'($urandom_range(0, 400)) - 16'd200;
                endcase
                put_sample(smp, 1'b0, NO_RES);
                sent++;
            end
        end

        settle();
        if (bad_beats == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
